>>> sv/assert_macros.svh
// Assertion helpers used by the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AEE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/aee_pkg.sv
package aee_pkg;

  // Name buffer size as seen by the configuration registers.
  localparam int NAME_CAP_BYTES = 32;
  localparam int NAME_BITS      = NAME_CAP_BYTES * 8;

  // APB port.
  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  localparam logic [2:0] REG_PACKAGE_LENGTH = 3'd0;
  localparam logic [2:0] REG_WANTED_LENGTH  = 3'd1;
  localparam logic [2:0] REG_NAME_WORD0     = 3'd2;
  localparam logic [2:0] REG_NAME_WORD1     = 3'd3;
  localparam logic [2:0] REG_NAME_WORD2     = 3'd4;
  localparam logic [2:0] REG_NAME_WORD3     = 3'd5;

  // Result queue.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [30:0]          package_length;
    logic [5:0]           wanted_name_length;
    logic [NAME_BITS-1:0] wanted_name;
  } cfg_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_data;
    logic       done_res;
    logic       found;
  } res_t;

  typedef struct packed {
    logic [QCNT_W-1:0] cnt;
  } qstat_t;

endpackage

>>> sv/aee_ifs.sv
interface aee_in_if;
  logic       valid;
  logic       ready;
  logic       first_of_package;
  logic [7:0] in_data;

  modport source(output valid, output first_of_package, output in_data, input ready);
  modport sink(input valid, input first_of_package, input in_data, output ready);
endinterface

interface aee_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_data;
  logic       done_res;
  logic       found;

  modport source(output valid, output out_valid, output out_data, output done_res,
                 output found, input ready);
  modport sink(input valid, input out_valid, input out_data, input done_res,
               input found, output ready);
endinterface

>>> sv/aee_apb_regs.sv
module aee_apb_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aee_pkg::CFG_AW-1:0]  paddr,
  input  logic [aee_pkg::CFG_DW-1:0]  pwdata,
  output logic [aee_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output aee_pkg::cfg_t               cfg
);
  import aee_pkg::*;

  logic [30:0] pkg_len_r;
  logic [5:0]  wlen_r;
  logic [63:0] word0_r, word1_r, word2_r, word3_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  // Registers sit on 8-byte boundaries.
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkg_len_r <= '0;
      wlen_r    <= '0;
      word0_r   <= '0;
      word1_r   <= '0;
      word2_r   <= '0;
      word3_r   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PACKAGE_LENGTH: pkg_len_r <= pwdata[30:0];
        REG_WANTED_LENGTH:  wlen_r    <= pwdata[5:0];
        REG_NAME_WORD0:     word0_r   <= pwdata;
        REG_NAME_WORD1:     word1_r   <= pwdata;
        REG_NAME_WORD2:     word2_r   <= pwdata;
        REG_NAME_WORD3:     word3_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PACKAGE_LENGTH: prdata = {33'b0, pkg_len_r};
      REG_WANTED_LENGTH:  prdata = {58'b0, wlen_r};
      REG_NAME_WORD0:     prdata = word0_r;
      REG_NAME_WORD1:     prdata = word1_r;
      REG_NAME_WORD2:     prdata = word2_r;
      REG_NAME_WORD3:     prdata = word3_r;
      default:            prdata = '0;
    endcase
  end

  assign cfg.package_length     = pkg_len_r;
  assign cfg.wanted_name_length = wlen_r;
  assign cfg.wanted_name        = {word3_r, word2_r, word1_r, word0_r};

endmodule

>>> sv/aee_parser.sv
module aee_parser #(
  parameter int MAX_NAME_BYTES = aee_pkg::NAME_CAP_BYTES
) (
  input  logic            clk,
  input  logic            rst_n,
  aee_in_if.sink          in_if,
  input  aee_pkg::cfg_t   cfg,
  input  aee_pkg::qstat_t q_stat,
  output logic            push,
  output aee_pkg::res_t   push_word
);
  import aee_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_COUNT, PH_NAMELEN, PH_NAME, PH_CLEN, PH_SKIP, PH_EMIT
  } phase_t;

  // Input register.
  logic       stg_v_r;
  logic       stg_first_r;
  logic [7:0] stg_data_r;

  // Parse state.
  phase_t             phase_r, phase_nxt, phase_e;
  logic [1:0]         idx_r, idx_nxt, idx_e;
  logic [23:0]        asm_r, asm_nxt, asm_e;
  logic signed [33:0] br_r, br_nxt, br_e;
  logic [30:0]        ent_r, ent_nxt, ent_dec;
  logic [30:0]        cd_r, cd_nxt;
  logic [5:0]         nidx_r, nidx_nxt;
  logic               match_r, match_nxt;

  logic               in_fire;
  logic [QCNT_W-1:0]  occupancy;
  logic [31:0]        v_u;
  logic               v_neg;
  logic [30:0]        vpos;
  logic signed [33:0] rem4, diff;
  logic [7:0]         wanted_b;
  logic               res_push;
  res_t               res_word;

  // Space is reserved for the word held in the input register as well.
  assign occupancy   = q_stat.cnt + QCNT_W'(stg_v_r);
  assign in_if.ready = occupancy < QCNT_W'(QDEPTH);
  assign in_fire     = in_if.valid & in_if.ready;

  // A start marker restarts the parse before this byte is looked at.
  always_comb begin
    if (stg_first_r) begin
      br_e    = $signed({3'b000, cfg.package_length});
      phase_e = (cfg.package_length < 31'd4) ? PH_IDLE : PH_COUNT;
      idx_e   = '0;
      asm_e   = '0;
    end else begin
      br_e    = br_r;
      phase_e = phase_r;
      idx_e   = idx_r;
      asm_e   = asm_r;
    end
  end

  assign v_u      = {stg_data_r, asm_e};
  assign v_neg    = v_u[31];
  assign vpos     = v_neg ? 31'd0 : v_u[30:0];
  assign rem4     = br_e - 34'sd4;
  assign diff     = br_e - $signed({3'b000, vpos}) - 34'sd4;
  assign ent_dec  = ent_r - 31'd1;
  assign wanted_b = cfg.wanted_name[{nidx_r[4:0], 3'b000} +: 8];

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    asm_nxt   = asm_r;
    br_nxt    = br_r;
    ent_nxt   = ent_r;
    cd_nxt    = cd_r;
    nidx_nxt  = nidx_r;
    match_nxt = match_r;
    res_push  = 1'b0;
    res_word  = '{out_valid: 1'b0, out_data: 8'd0, done_res: 1'b1, found: 1'b0};

    if (stg_v_r) begin
      phase_nxt = phase_e;
      idx_nxt   = idx_e;
      asm_nxt   = asm_e;
      br_nxt    = br_e;
      unique case (phase_e)
        PH_COUNT, PH_NAMELEN, PH_CLEN: begin
          if (idx_e != 2'd3) begin
            asm_nxt[{idx_e, 3'b000} +: 8] = stg_data_r;
            idx_nxt = idx_e + 2'd1;
          end else begin
            idx_nxt = '0;
            asm_nxt = '0;
            br_nxt  = rem4;
            if (phase_e == PH_COUNT) begin
              if (v_neg || v_u == 32'd0 || rem4 < 34'sd4) begin
                res_push  = 1'b1;
                phase_nxt = PH_IDLE;
              end else begin
                ent_nxt   = v_u[30:0];
                phase_nxt = PH_NAMELEN;
              end
            end else if (phase_e == PH_NAMELEN) begin
              if (v_neg || diff < 34'sd4) begin
                res_push  = 1'b1;
                phase_nxt = PH_IDLE;
              end else begin
                match_nxt = (cfg.wanted_name_length <= 6'(MAX_NAME_BYTES)) &&
                            (v_u == {26'b0, cfg.wanted_name_length});
                br_nxt    = diff;
                nidx_nxt  = '0;
                cd_nxt    = v_u[30:0];
                phase_nxt = (v_u == 32'd0) ? PH_CLEN : PH_NAME;
              end
            end else if (match_r) begin
              if (v_neg || diff[33]) begin
                res_push  = 1'b1;
                phase_nxt = PH_IDLE;
              end else if (v_u == 32'd0) begin
                // Matched entry with empty content.
                res_push       = 1'b1;
                res_word.found = 1'b1;
                phase_nxt      = PH_IDLE;
              end else begin
                cd_nxt    = v_u[30:0];
                phase_nxt = PH_EMIT;
              end
            end else begin
              // Missing files count as empty when skipped.
              br_nxt  = diff;
              ent_nxt = ent_dec;
              if (diff[33]) begin
                res_push  = 1'b1;
                phase_nxt = PH_IDLE;
              end else if (vpos == 31'd0) begin
                if (ent_dec == 31'd0 || diff < 34'sd4) begin
                  res_push  = 1'b1;
                  phase_nxt = PH_IDLE;
                end else begin
                  phase_nxt = PH_NAMELEN;
                end
              end else begin
                cd_nxt    = vpos;
                phase_nxt = PH_SKIP;
              end
            end
          end
        end
        PH_NAME: begin
          if (match_r && (nidx_r >= 6'(MAX_NAME_BYTES) || stg_data_r != wanted_b)) begin
            match_nxt = 1'b0;
          end
          nidx_nxt = nidx_r + 6'd1;
          cd_nxt   = cd_r - 31'd1;
          if (cd_r == 31'd1) begin
            phase_nxt = PH_CLEN;
          end
        end
        PH_SKIP: begin
          cd_nxt = cd_r - 31'd1;
          if (cd_r == 31'd1) begin
            if (ent_r == 31'd0 || br_e < 34'sd4) begin
              res_push  = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_NAMELEN;
            end
          end
        end
        PH_EMIT: begin
          cd_nxt             = cd_r - 31'd1;
          res_push           = 1'b1;
          res_word.out_valid = 1'b1;
          res_word.out_data  = stg_data_r;
          res_word.done_res  = (cd_r == 31'd1);
          res_word.found     = (cd_r == 31'd1);
          if (cd_r == 31'd1) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_IDLE: begin
          // Only a start on a package too short for its count pushes a word here.
          res_push = stg_first_r;
        end
        default: ;
      endcase
    end
  end

  assign push      = res_push;
  assign push_word = res_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r  <= 1'b0;
      phase_r  <= PH_IDLE;
      idx_r    <= '0;
      asm_r    <= '0;
      br_r     <= '0;
      ent_r    <= '0;
      cd_r     <= '0;
      nidx_r   <= '0;
      match_r  <= 1'b0;
    end else begin
      stg_v_r  <= in_fire;
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      asm_r    <= asm_nxt;
      br_r     <= br_nxt;
      ent_r    <= ent_nxt;
      cd_r     <= cd_nxt;
      nidx_r   <= nidx_nxt;
      match_r  <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_first_r <= in_if.first_of_package;
      stg_data_r  <= in_if.in_data;
    end
  end

endmodule

>>> sv/aee_res_queue.sv
module aee_res_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  aee_pkg::res_t    push_word,
  output aee_pkg::qstat_t  q_stat,
  aee_out_if.source        out_if
);
  import aee_pkg::*;

  res_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              pop;
  res_t              head;

  assign head             = mem_r[rd_ptr_r];
  assign out_if.valid     = cnt_r != '0;
  assign out_if.out_valid = head.out_valid;
  assign out_if.out_data  = head.out_data;
  assign out_if.done_res  = head.done_res;
  assign out_if.found     = head.found;
  assign pop              = out_if.valid & out_if.ready;
  assign q_stat.cnt       = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

>>> sv/archive_entry_extractor.sv
// Channel  Dir  Handshake          Payload
// in_if    in   valid / ready      first_of_package, in_data
// out_if   out  valid / ready      out_valid, out_data, done_res, found
// apb      in   psel, penable      paddr, pwdata -> prdata (pready tied high)
//
// One byte per cycle is taken while in_if.ready is high; each byte is held in the input register
// and its result word, if any, is written into a four-word result queue.
// A result word passes through the input register and then the queue memory before it
// appears on out_if, behind any words still waiting in the queue.
// in_if.ready drops only when the queue plus the input register could overflow.
// Reset (rst_n low, synchronous) returns the parser to idle and empties the queue.
`include "assert_macros.svh"

module archive_entry_extractor #(
  parameter int MAX_NAME_BYTES = aee_pkg::NAME_CAP_BYTES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  aee_in_if.sink                     in_if,
  aee_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aee_pkg::CFG_AW-1:0] paddr,
  input  logic [aee_pkg::CFG_DW-1:0] pwdata,
  output logic [aee_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import aee_pkg::*;

  cfg_t   cfg;
  qstat_t q_stat;
  logic   push;
  res_t   push_word;

  aee_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aee_parser #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .push      (push),
    .push_word (push_word)
  );

  aee_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .q_stat    (q_stat),
    .out_if    (out_if)
  );

  // The input-side reservation must keep the queue from ever overflowing.
  `AEE_ASSERT_NOW(a_no_overflow, push, q_stat.cnt != QCNT_W'(QDEPTH), "result queue overflow")
  // Found is only reported on the word that ends the search.
  `AEE_ASSERT_NOW(a_found_done, out_if.valid && out_if.found, out_if.done_res, "found without done")
  // A word without a content byte is always a final status with zero data.
  `AEE_ASSERT_NOW(a_status_word, out_if.valid && !out_if.out_valid,
                  out_if.done_res && out_if.out_data == 8'd0, "bad status word")
  // At most one word is pushed per cycle, so an empty queue holds at most one word next.
  `AEE_ASSERT_NEXT(a_cnt_step, q_stat.cnt == '0, q_stat.cnt <= QCNT_W'(1), "queue count jumped")

endmodule

>>> tb/archive_entry_extractor_test.sv
`timescale 1ns / 1ps

module archive_entry_extractor_test;
  import aee_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 7;
  localparam int DRAIN_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_BYTES   = 300;
  localparam int TIMEOUT_CYCLES = 1_000_000;

  // Addresses past the last register; writes there must change nothing.
  localparam logic [2:0] REG_SPARE6 = 3'd6;
  localparam logic [2:0] REG_SPARE7 = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE, PH_COUNT, PH_NAMELEN, PH_NAME, PH_CLEN, PH_SKIP, PH_EMIT
  } parse_phase_e;

  typedef enum int {NAME_MIXED, NAME_ONES, NAME_ZEROS} name_fill_e;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  aee_in_if  in_ch();
  aee_out_if out_ch();

  archive_entry_extractor u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Register copies and parser state of the predictor.
  logic [30:0]          cfg_pkg_len;
  logic [5:0]           cfg_name_len;
  logic [NAME_BITS-1:0] cfg_name;
  parse_phase_e         m_phase;
  logic [1:0]           m_idx;
  logic [31:0]          m_asm;
  longint               m_left;
  logic [31:0]          m_entries;
  logic [31:0]          m_count;
  logic [5:0]           m_name_idx;
  bit                   m_match;

  res_t       pending_results[$];
  logic [7:0] pkt[$];

  bit steady;
  int hold_req, hold_left, stall_left;
  int errors, n_bytes, n_results, n_found, n_absent, n_packages, n_writes;

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("%0t: timed out with %0d result words outstanding", $time,
             pending_results.size());
    $display("status: fail");
    $finish;
  end

  function automatic bit search_absent(output res_t r);
    r = '0;
    r.done_res = 1'b1;
    m_phase = PH_IDLE;
    return 1'b1;
  endfunction

  function automatic bit open_entry(output res_t r);
    r = '0;
    if (m_entries == 0 || m_left < 4) return search_absent(r);
    m_phase = PH_NAMELEN;
    m_idx = '0;
    m_asm = '0;
    return 1'b0;
  endfunction

  // Advances the predicted parser by one archive byte; returns 1 when the byte
  // produces a result word.
  function automatic bit step_archive(input bit first, input logic [7:0] b,
                                      output res_t r);
    longint v;
    r = '0;
    if (first) begin
      m_left = longint'(cfg_pkg_len);
      if (m_left < 4) return search_absent(r);
      m_phase = PH_COUNT;
      m_idx = '0;
      m_asm = '0;
    end
    case (m_phase)
      PH_COUNT, PH_NAMELEN, PH_CLEN: begin
        m_asm = m_asm | (32'(b) << (8 * m_idx));
        if (m_idx < 3) begin
          m_idx++;
          return 1'b0;
        end
        v = $signed(m_asm);
        m_idx = '0;
        m_asm = '0;
        m_left -= 4;
        if (m_phase == PH_COUNT) begin
          if (v <= 0) return search_absent(r);
          m_entries = v[31:0];
          return open_entry(r);
        end
        if (m_phase == PH_NAMELEN) begin
          if (v < 0 || m_left < v + 4) return search_absent(r);
          m_match = (cfg_name_len <= NAME_CAP_BYTES) && (v == longint'(cfg_name_len));
          m_left -= v;
          m_name_idx = '0;
          m_count = v[31:0];
          m_phase = (v == 0) ? PH_CLEN : PH_NAME;
          return 1'b0;
        end
        if (m_match) begin
          if (v < 0 || m_left < v) return search_absent(r);
          if (v == 0) begin
            r.done_res = 1'b1;
            r.found = 1'b1;
            m_phase = PH_IDLE;
            return 1'b1;
          end
          m_count = v[31:0];
          m_phase = PH_EMIT;
          return 1'b0;
        end
        // A missing file in a skipped entry has no content bytes.
        if (v < 0) v = 0;
        m_left -= v;
        m_entries--;
        if (m_left < 0) return search_absent(r);
        if (v == 0) return open_entry(r);
        m_count = v[31:0];
        m_phase = PH_SKIP;
        return 1'b0;
      end
      PH_NAME: begin
        if (m_match && (m_name_idx >= NAME_CAP_BYTES || b != cfg_name[8*m_name_idx +: 8]))
          m_match = 1'b0;
        m_name_idx++;
        m_count--;
        if (m_count == 0) m_phase = PH_CLEN;
        return 1'b0;
      end
      PH_SKIP: begin
        m_count--;
        if (m_count == 0) return open_entry(r);
        return 1'b0;
      end
      PH_EMIT: begin
        m_count--;
        r.out_valid = 1'b1;
        r.out_data = b;
        if (m_count == 0) begin
          r.done_res = 1'b1;
          r.found = 1'b1;
          m_phase = PH_IDLE;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, expected nothing, got %0b %02h %0b %0b",
                 $time, out_ch.out_valid, out_ch.out_data, out_ch.done_res, out_ch.found);
      end else begin
        want = pending_results.pop_front();
        check_field("out_valid", 8'(want.out_valid), 8'(out_ch.out_valid));
        check_field("out_data", want.out_data, out_ch.out_data);
        check_field("done_res", 8'(want.done_res), 8'(out_ch.done_res));
        check_field("found", 8'(want.found), 8'(out_ch.found));
        if (want.done_res && want.found) n_found++;
        else if (want.done_res) n_absent++;
      end
    end
  end

  // Output side: a random stall after each word, or a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= (hold_left == 0);
    end else if (out_ch.valid && out_ch.ready) begin
      stall_left = steady ? 0 : $urandom_range(0, 14);
      out_ch.ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= (stall_left == 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_byte(input bit first, input logic [7:0] b);
    int gap;
    res_t r;
    gap = steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.first_of_package <= first;
    in_ch.in_data <= b;
    do @(posedge clk); while (!in_ch.ready);
    n_bytes++;
    if (step_archive(first, b, r)) pending_results.push_back(r);
  endtask

  task automatic send_package();
    n_packages++;
    foreach (pkt[i]) send_byte(i == 0, pkt[i]);
  endtask

  function automatic void add_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) pkt.push_back(w[8*i +: 8]);
  endfunction

  // Brings the block to rest: no word offered, every result drained.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PACKAGE_LENGTH: cfg_pkg_len = val[30:0];
      REG_WANTED_LENGTH:  cfg_name_len = val[5:0];
      REG_NAME_WORD0:     cfg_name[63:0] = val;
      REG_NAME_WORD1:     cfg_name[127:64] = val;
      REG_NAME_WORD2:     cfg_name[191:128] = val;
      REG_NAME_WORD3:     cfg_name[255:192] = val;
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
  endtask

  task automatic set_wanted_name(input logic [5:0] len, input name_fill_e fill);
    logic [NAME_BITS-1:0] name;
    for (int i = 0; i < NAME_CAP_BYTES; i++) begin
      case (fill)
        NAME_ONES:  name[8*i +: 8] = 8'hFF;
        NAME_ZEROS: name[8*i +: 8] = 8'h00;
        default:    name[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
      endcase
    end
    settle();
    write_reg(REG_WANTED_LENGTH, 64'(len));
    write_reg(REG_NAME_WORD0, name[63:0]);
    write_reg(REG_NAME_WORD1, name[127:64]);
    write_reg(REG_NAME_WORD2, name[191:128]);
    write_reg(REG_NAME_WORD3, name[255:192]);
  endtask

  task automatic set_package_length(input logic [30:0] len);
    settle();
    write_reg(REG_PACKAGE_LENGTH, 64'(len));
  endtask

  // Stray bytes before any start, then packages too short to hold a count.
  task automatic test_idle_and_short();
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b1, 8'h5A);
    set_package_length(31'd3);
    send_byte(1'b1, 8'hA5);
  endtask

  task automatic test_bad_count();
    set_package_length(31'd4);
    pkt.delete();
    add_word(32'hFFFF_FFFF);
    send_package();
  endtask

  // Largest package and largest name length register value; the name length
  // field cannot fit even in the largest package.
  task automatic test_huge_length();
    set_wanted_name(6'd63, NAME_ONES);
    set_package_length(31'h7FFF_FFFF);
    pkt.delete();
    add_word(32'd1);
    add_word(32'h7FFF_FFFF);
    send_package();
  endtask

  task automatic test_empty_match();
    set_wanted_name(6'd0, NAME_ZEROS);
    write_reg(REG_SPARE6, {$urandom, $urandom});
    write_reg(REG_SPARE7, {$urandom, $urandom});
    write_reg(REG_PACKAGE_LENGTH, 64'd12);
    pkt.delete();
    add_word(32'd1);
    add_word(32'd0);
    add_word(32'd0);
    send_package();
  endtask

  // The receiver holds off while a long matching entry streams in, so the
  // result queue fills and the input must stall.
  task automatic test_backpressure();
    set_wanted_name(6'd3, NAME_MIXED);
    pkt.delete();
    add_word(32'd2);
    add_word(32'd5);
    repeat (5) pkt.push_back(8'($urandom));
    add_word(32'd4);
    repeat (4) pkt.push_back(8'($urandom));
    add_word(32'd3);
    for (int i = 0; i < 3; i++) pkt.push_back(cfg_name[8*i +: 8]);
    add_word(32'd40);
    repeat (40) pkt.push_back(8'($urandom));
    set_package_length(31'(pkt.size()));
    steady = 1'b1;
    hold_req = HOLD_CYCLES;
    send_package();
    steady = 1'b0;
  endtask

  task automatic test_random_archives();
    int parsed, n_ent, count, kind, nlen, clen, flip_at, sel, cut;
    logic [30:0] plen;
    logic [7:0] b;
    parsed = 0;
    while (parsed < RANDOM_BYTES) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) nlen = 0;
        else if (sel < 3) nlen = NAME_CAP_BYTES;
        else if (sel < 6) nlen = $urandom_range(NAME_CAP_BYTES + 1, 63);
        else nlen = $urandom_range(1, 6);
        sel = $urandom_range(0, 9);
        set_wanted_name(6'(nlen), sel == 0 ? NAME_ONES : sel == 1 ? NAME_ZEROS : NAME_MIXED);
      end

      pkt.delete();
      n_ent = $urandom_range(1, 3);
      sel = $urandom_range(0, 9);
      if (sel == 0) count = n_ent + 1;
      else if (sel == 1) count = $urandom_range(0, n_ent - 1);
      else if (sel == 2) count = 32'h8000_0000 | $urandom;
      else count = n_ent;
      add_word(32'(count));
      for (int e = 0; e < n_ent; e++) begin
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
          add_word(32'h8000_0000 | $urandom);
          continue;
        end
        flip_at = -1;
        if (kind < 5) nlen = cfg_name_len;
        else if (kind == 5) nlen = (cfg_name_len > 0 && $urandom_range(0, 1)) ?
                                   cfg_name_len - 1 : cfg_name_len + 1;
        else nlen = $urandom_range(0, 6);
        if (kind == 4 && nlen > 0) flip_at = $urandom_range(0, nlen - 1);
        add_word(32'(nlen));
        for (int i = 0; i < nlen; i++) begin
          if (kind < 6 && i < NAME_CAP_BYTES) b = cfg_name[8*i +: 8];
          else b = 8'($urandom);
          if (i == flip_at) b = b ^ (8'h01 << $urandom_range(0, 7));
          pkt.push_back(b);
        end
        sel = $urandom_range(0, 19);
        if (sel == 0) clen = -1;
        else if (sel == 1) clen = 32'h8000_0000 | $urandom;
        else if (sel == 2) clen = $urandom_range(100, 1000);
        else clen = $urandom_range(0, 8);
        add_word(32'(clen));
        if (clen >= 0 && clen <= 8) repeat (clen) pkt.push_back(8'($urandom));
      end
      parsed += pkt.size();

      sel = $urandom_range(0, 19);
      if (sel < 13) plen = 31'(pkt.size());
      else if (sel < 15) plen = (pkt.size() > 6) ? 31'(pkt.size() - $urandom_range(1, 6)) : '0;
      else if (sel < 17) plen = 31'(pkt.size() + $urandom_range(1, 10));
      else if (sel < 19) plen = 31'($urandom_range(0, 4));
      else plen = 31'h7FFF_FFFF;
      if (plen != cfg_pkg_len) set_package_length(plen);

      // Occasional corruption, early restart, or trailing bytes to be ignored.
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(0, pkt.size() - 1);
        pkt[cut] = pkt[cut] ^ (8'h01 << $urandom_range(0, 7));
      end
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        cut = $urandom_range(0, pkt.size() - 1);
        pkt = pkt[0:cut];
      end else if (sel == 1) begin
        repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
      end
      send_package();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.first_of_package = 1'b0;
    in_ch.in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_pkg_len = '0;
    cfg_name_len = '0;
    cfg_name = '0;
    m_phase = PH_IDLE;
    m_idx = '0;
    m_asm = '0;
    m_left = 0;
    m_entries = '0;
    m_count = '0;
    m_name_idx = '0;
    m_match = 1'b0;
    steady = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_and_short();
    test_bad_count();
    test_huge_length();
    test_empty_match();
    test_backpressure();
    test_random_archives();
    settle();

    $display("Run covered %0d archives and %0d input bytes over %0d register writes.",
             n_packages, n_bytes, n_writes);
    $display("Checked %0d result words: %0d searches found, %0d absent.",
             n_results, n_found, n_absent);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/aee_pkg.sv
sv/aee_ifs.sv
sv/aee_apb_regs.sv
sv/aee_parser.sv
sv/aee_res_queue.sv
sv/archive_entry_extractor.sv
tb/archive_entry_extractor_test.sv
